// ===== hdl/edge_adaptive_box_blur_defines.svh =====
// Assertion macros used by the blur back end
`ifndef EDGE_ADAPTIVE_BOX_BLUR_DEFINES_SVH
`define EDGE_ADAPTIVE_BOX_BLUR_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet while rst_n is low
`define EABB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EABB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/eabb_pkg.sv =====
// Types and constants of the edge-adaptive box blur
`default_nettype none
package eabb_pkg;

  localparam int PIX_BITS = 8;
  localparam int FW_BITS  = 11;
  localparam int FH_BITS  = 13;
  localparam int ROW_BITS = FH_BITS + 1;

  localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

  localparam logic REG_WIDTH_IDX  = 1'b0;
  localparam logic REG_HEIGHT_IDX = 1'b1;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SIZE,
    BS_SUM,
    BS_DRAIN,
    BS_DIV,
    BS_DONE
  } back_state_t;

  // window half-size for an edge distance, before the cap by the window limit
  function automatic logic [2:0] half_size_base(input logic [PIX_BITS-1:0] edist);
    logic [2:0] h;
    if (edist <= 8'd1) h = 3'd0;
    else if (edist <= 8'd3) h = 3'd1;
    else if (edist <= 8'd5) h = 3'd2;
    else if (edist <= 8'd7) h = 3'd3;
    else h = 3'd4;
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/eabb_ram.sv =====
// Generic single-write, single-read RAM with registered read
`default_nettype none
module eabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/eabb_queue.sv =====
// Two-entry job queue between front and back
`default_nettype none
module eabb_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/eabb_front.sv =====
// Front: takes items, writes line stores, tracks raster positions, issues jobs
`default_nettype none
module eabb_front #(
  parameter int HALF      = 4,
  parameter int RR        = 18,
  parameter int SW        = 5,
  parameter int CW        = 10,
  parameter int WW        = 11,
  parameter int HW        = 3,
  parameter int QW        = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              restart,
  input  wire logic [WW-1:0]                     eff_w,
  input  wire logic [eabb_pkg::FH_BITS-1:0]      eff_h,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [eabb_pkg::PIX_BITS-1:0]     in_pixel,
  input  wire logic [eabb_pkg::PIX_BITS-1:0]     in_edge_distance,
  input  wire logic                              in_is_padding,
  input  wire logic                              job_full,
  output logic                                   job_push,
  output logic [eabb_pkg::FH_BITS-1:0]           job_row,
  output logic [CW-1:0]                          job_col,
  output logic [SW-1:0]                          job_slot,
  output logic                                   job_end,
  output logic                                   st_we,
  output logic [SW+CW-1:0]                       st_waddr,
  output logic [eabb_pkg::PIX_BITS-1:0]          pix_wdata,
  output logic [HW-1:0]                          size_wdata
);
  import eabb_pkg::*;

  logic [CW-1:0]       in_col_r, in_col_nxt;
  logic [ROW_BITS-1:0] in_row_r, in_row_nxt;
  logic [SW-1:0]       in_slot_r, in_slot_nxt;
  logic [QW-1:0]       q_r, q_nxt;
  logic [CW-1:0]       out_col_r, out_col_nxt;
  logic [FH_BITS-1:0]  out_row_r, out_row_nxt;
  logic [SW-1:0]       out_slot_r, out_slot_nxt;

  logic          take, in_frame, col_last, has_res, frame_end, out_col_last;
  logic [QW-1:0] delay;
  logic [2:0]    hb;
  logic [SW-1:0] slot_inc, out_slot_inc;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(RR - 1)) ? '0 : s + SW'(1);
  endfunction

  assign in_full  = job_full;
  assign take     = in_push && !in_full;
  assign in_frame = (in_row_r < {1'b0, eff_h}) && (WW'(in_col_r) < eff_w);
  assign col_last = (WW'(in_col_r) == eff_w - WW'(1));
  assign delay    = QW'(HALF) * QW'(eff_w) + QW'(HALF);
  assign has_res  = (q_r >= delay);
  assign out_col_last = (WW'(out_col_r) == eff_w - WW'(1));
  assign frame_end = out_col_last && (out_row_r == eff_h - FH_BITS'(1));
  assign slot_inc = next_slot(in_slot_r);
  assign out_slot_inc = next_slot(out_slot_r);

  assign hb         = half_size_base(in_edge_distance);
  assign st_we      = take && in_frame;
  assign st_waddr   = {in_slot_r, in_col_r};
  assign pix_wdata  = in_is_padding ? '0 : in_pixel;
  assign size_wdata = in_is_padding ? '0 :
                      ((32'(hb) > HALF) ? HW'(HALF) : HW'(hb));

  assign job_push = take && has_res;
  assign job_row  = out_row_r;
  assign job_col  = out_col_r;
  assign job_slot = out_slot_r;
  assign job_end  = frame_end;

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    q_nxt        = q_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    if (restart) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      q_nxt        = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
    end else if (take) begin
      q_nxt = q_r + QW'(1);
      if (col_last) begin
        in_col_nxt  = '0;
        in_row_nxt  = in_row_r + ROW_BITS'(1);
        in_slot_nxt = slot_inc;
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (has_res) begin
        if (frame_end) begin
          // new frame starts on the ring row after the last output row, so the rows
          // that pending jobs still read stay untouched while the new frame fills up
          in_col_nxt   = '0;
          in_row_nxt   = '0;
          q_nxt        = '0;
          out_col_nxt  = '0;
          out_row_nxt  = '0;
          in_slot_nxt  = out_slot_inc;
          out_slot_nxt = out_slot_inc;
        end else if (out_col_last) begin
          out_col_nxt  = '0;
          out_row_nxt  = out_row_r + FH_BITS'(1);
          out_slot_nxt = out_slot_inc;
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      q_r        <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      q_r        <= q_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/eabb_back.sv =====
// Back: sums the clipped window over the pixel store, divides, holds the result
`default_nettype none
`include "edge_adaptive_box_blur_defines.svh"
module eabb_back #(
  parameter int MAX_WINDOW = 9,
  parameter int RR         = 18,
  parameter int SW         = 5,
  parameter int CW         = 10,
  parameter int WW         = 11,
  parameter int HW         = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [WW-1:0]                 eff_w,
  input  wire logic [eabb_pkg::FH_BITS-1:0]  eff_h,
  input  wire logic                          job_empty,
  output logic                               job_pop,
  input  wire logic [eabb_pkg::FH_BITS-1:0]  job_row,
  input  wire logic [CW-1:0]                 job_col,
  input  wire logic [SW-1:0]                 job_slot,
  input  wire logic                          job_end,
  output logic [SW+CW-1:0]                   size_raddr,
  input  wire logic [HW-1:0]                 size_rdata,
  output logic [SW+CW-1:0]                   pix_raddr,
  input  wire logic [eabb_pkg::PIX_BITS-1:0] pix_rdata,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [eabb_pkg::PIX_BITS-1:0]      out_filtered_pixel,
  output logic                               out_frame_end
);
  import eabb_pkg::*;

  localparam int SUMW = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int CNTW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int DW   = $clog2(MAX_WINDOW + 1);
  localparam int STW  = $clog2(SUMW + 1);

  back_state_t state_r, state_nxt;

  logic [FH_BITS-1:0]  jrow_r, r_r, r1_r;
  logic [CW-1:0]       jcol_r, c_r, c0_r, c1_r;
  logic [SW-1:0]       jslot_r, rs_r;
  logic                jend_r;
  logic [DW-1:0]       nrows_r, ncols_r;
  logic [CNTW-1:0]     cnt_r, rem_r;
  logic [SUMW-1:0]     acc_r;
  logic [STW-1:0]      dstep_r;
  logic                acc_en_r;
  logic                out_vld_r;

  logic                 last_col, last_pix, div_last, out_load;
  logic [ROW_BITS-1:0]  row_hi;
  logic [WW:0]          col_hi;
  logic [FH_BITS-1:0]   r0_w, r1_w;
  logic [CW-1:0]        c0_w, c1_w;
  logic [SW-1:0]        d_w, rs0_w;
  logic [CNTW:0]        trial;
  logic                 q_bit;

  assign last_col = (c_r == c1_r);
  assign last_pix = last_col && (r_r == r1_r);
  assign div_last = (dstep_r == STW'(SUMW - 1));
  assign out_empty = !out_vld_r;

  // clipped window bounds for the half-size just read
  always_comb begin
    row_hi = ROW_BITS'(jrow_r) + ROW_BITS'(size_rdata);
    col_hi = (WW + 1)'(jcol_r) + (WW + 1)'(size_rdata);
    r0_w = (jrow_r >= FH_BITS'(size_rdata)) ? jrow_r - FH_BITS'(size_rdata) : '0;
    r1_w = (row_hi < ROW_BITS'(eff_h)) ? row_hi[FH_BITS-1:0] : eff_h - FH_BITS'(1);
    c0_w = (jcol_r >= CW'(size_rdata)) ? jcol_r - CW'(size_rdata) : '0;
    c1_w = (col_hi < (WW + 1)'(eff_w)) ? col_hi[CW-1:0] : CW'(eff_w - WW'(1));
    d_w   = SW'(jrow_r - r0_w);
    rs0_w = (jslot_r >= d_w) ? jslot_r - d_w : jslot_r + SW'(RR) - d_w;
  end

  // one restoring division step
  always_comb begin
    trial = {rem_r, acc_r[SUMW-1]} - {1'b0, cnt_r};
    q_bit = !trial[CNTW];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE:  if (!job_empty) state_nxt = BS_SIZE;
      BS_SIZE:  state_nxt = BS_SUM;
      BS_SUM:   if (last_pix) state_nxt = BS_DRAIN;
      BS_DRAIN: state_nxt = BS_DIV;
      BS_DIV:   if (div_last) state_nxt = BS_DONE;
      BS_DONE:  if (!out_vld_r || out_pop) state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = 1'b0;
    out_load   = 1'b0;
    size_raddr = {job_slot, job_col};
    pix_raddr  = {rs_r, c_r};
    unique case (state_r)
      BS_IDLE: job_pop  = !job_empty;
      BS_DONE: out_load = !out_vld_r || out_pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BS_IDLE;
      acc_en_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= (state_r == BS_SUM);
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      jrow_r  <= job_row;
      jcol_r  <= job_col;
      jslot_r <= job_slot;
      jend_r  <= job_end;
    end
    if (state_r == BS_SIZE) begin
      r_r     <= r0_w;
      r1_r    <= r1_w;
      c_r     <= c0_w;
      c0_r    <= c0_w;
      c1_r    <= c1_w;
      rs_r    <= rs0_w;
      nrows_r <= DW'(r1_w - r0_w) + DW'(1);
      ncols_r <= DW'(c1_w - c0_w) + DW'(1);
      acc_r   <= '0;
    end else if (state_r == BS_SUM) begin
      if (last_col) begin
        c_r  <= c0_r;
        r_r  <= r_r + FH_BITS'(1);
        rs_r <= (rs_r == SW'(RR - 1)) ? '0 : rs_r + SW'(1);
      end else begin
        c_r <= c_r + CW'(1);
      end
    end
    if (acc_en_r) begin
      acc_r <= acc_r + SUMW'(pix_rdata);
    end
    if (state_r == BS_DRAIN) begin
      cnt_r   <= CNTW'(nrows_r * ncols_r);
      rem_r   <= '0;
      dstep_r <= '0;
    end
    if (state_r == BS_DIV) begin
      rem_r   <= q_bit ? trial[CNTW-1:0] : {rem_r[CNTW-2:0], acc_r[SUMW-1]};
      acc_r   <= {acc_r[SUMW-2:0], q_bit};
      dstep_r <= dstep_r + STW'(1);
    end
    if (out_load) begin
      out_filtered_pixel <= acc_r[PIX_BITS-1:0];
      out_frame_end      <= jend_r;
    end
  end

  `EABB_ASSERT_NOW(a_no_overwrite, out_load, (!out_vld_r || out_pop), "result overwritten")
  `EABB_ASSERT_NOW(a_mean_fits, state_r == BS_DONE, (acc_r[SUMW-1:PIX_BITS] == '0), "mean overflow")
  `EABB_ASSERT_NOW(a_col_in_window, state_r == BS_SUM, (c_r >= c0_r && c_r <= c1_r), "column out of window")
  `EABB_ASSERT_NEXT(a_acc_after_sum, state_r == BS_SUM, acc_en_r, "pixel read not accumulated")

endmodule
`default_nettype wire

// ===== hdl/edge_adaptive_box_blur.sv =====
// Latency: results trail inputs by HALF rows plus HALF items of the frame (HALF = MAX_WINDOW/2).
// Each result holds the back end for one pixel store read per window pixel (R x C = clipped
// window), 15 steps of a one-bit-per-cycle divider and the IDLE, SIZE, DRAIN and DONE states.
// Items that make no result are taken at one per cycle while the job queue has room.
// Reset (rst_n low, synchronous): positions, queue and result valid flag cleared; width 640, height 480.
// Line stores are not cleared; every read hits an entry written earlier in the frame.
`default_nettype none
module edge_adaptive_box_blur #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [eabb_pkg::PIX_BITS-1:0] in_pixel,
  input  wire logic [eabb_pkg::PIX_BITS-1:0] in_edge_distance,
  input  wire logic                          in_is_padding,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [eabb_pkg::PIX_BITS-1:0]      out_filtered_pixel,
  output logic                               out_frame_end,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import eabb_pkg::*;

  localparam int HALF = MAX_WINDOW / 2;
  localparam int RR   = 2 * MAX_WINDOW;
  localparam int SW   = $clog2(RR);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(HALF + 1);
  localparam int QW   = $clog2(((1 << FH_BITS) + HALF + 1) * MAX_WIDTH);
  localparam int JW   = FH_BITS + CW + SW + 1;

  logic [FW_BITS-1:0] fw_r;
  logic [FH_BITS-1:0] fh_r;
  logic               cfg_wr;
  logic [WW-1:0]      eff_w;
  logic [FH_BITS-1:0] eff_h;

  logic               job_full, job_push, job_empty, job_pop;
  logic [JW-1:0]      job_wdata, job_rdata;
  logic [FH_BITS-1:0] f_row, b_row;
  logic [CW-1:0]      f_col, b_col;
  logic [SW-1:0]      f_slot, b_slot;
  logic               f_end, b_end;

  logic               st_we;
  logic [SW+CW-1:0]   st_waddr, size_raddr, pix_raddr;
  logic [PIX_BITS-1:0] pix_wdata, pix_rdata;
  logic [HW-1:0]      size_wdata, size_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEIGHT_IDX) ? 32'(fh_r) : 32'(fw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH_IDX) begin
        fw_r <= pwdata[FW_BITS-1:0];
      end else begin
        fh_r <= pwdata[FH_BITS-1:0];
      end
    end
  end

  assign eff_w = (fw_r == '0) ? WW'(1) :
                 ((32'(fw_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(fw_r));
  assign eff_h = (fh_r == '0) ? FH_BITS'(1) : fh_r;

  assign job_wdata = {f_row, f_col, f_slot, f_end};
  assign {b_row, b_col, b_slot, b_end} = job_rdata;

  eabb_front #(
    .HALF(HALF), .RR(RR), .SW(SW),
    .CW(CW), .WW(WW), .HW(HW), .QW(QW)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .restart(cfg_wr),
    .eff_w(eff_w), .eff_h(eff_h),
    .in_push(in_push), .in_full(in_full),
    .in_pixel(in_pixel), .in_edge_distance(in_edge_distance),
    .in_is_padding(in_is_padding),
    .job_full(job_full), .job_push(job_push),
    .job_row(f_row), .job_col(f_col), .job_slot(f_slot), .job_end(f_end),
    .st_we(st_we), .st_waddr(st_waddr),
    .pix_wdata(pix_wdata), .size_wdata(size_wdata)
  );

  eabb_queue #(.W(JW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(job_push), .wdata(job_wdata), .full(job_full),
    .pop(job_pop), .rdata(job_rdata), .empty(job_empty)
  );

  eabb_ram #(.WIDTH(PIX_BITS), .DEPTH(RR * (1 << CW))) u_pix_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(pix_wdata),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );

  eabb_ram #(.WIDTH(HW), .DEPTH(RR * (1 << CW))) u_size_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(size_wdata),
    .raddr(size_raddr), .rdata(size_rdata)
  );

  eabb_back #(
    .MAX_WINDOW(MAX_WINDOW), .RR(RR), .SW(SW), .CW(CW), .WW(WW), .HW(HW)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .eff_w(eff_w), .eff_h(eff_h),
    .job_empty(job_empty), .job_pop(job_pop),
    .job_row(b_row), .job_col(b_col), .job_slot(b_slot), .job_end(b_end),
    .size_raddr(size_raddr), .size_rdata(size_rdata),
    .pix_raddr(pix_raddr), .pix_rdata(pix_rdata),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_filtered_pixel(out_filtered_pixel), .out_frame_end(out_frame_end)
  );

endmodule
`default_nettype wire

// ===== tb/sv/edge_adaptive_box_blur_checker.sv =====
// Checker for the edge-adaptive box blur: predicts every result and compares it
`timescale 1ns / 100ps
`default_nettype none
module edge_adaptive_box_blur_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic        in_full,
  input  wire logic [7:0]  in_pixel,
  input  wire logic [7:0]  in_edge_distance,
  input  wire logic        in_is_padding,
  input  wire logic        out_empty,
  input  wire logic        out_pop,
  input  wire logic [7:0]  out_filtered_pixel,
  input  wire logic        out_frame_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               errors,
  output int               pending
);
  import eabb_pkg::*;

  localparam int LINE_MAX  = 1024;
  localparam int HALF      = 4;
  localparam int RING_ROWS = 18;
  localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH_IDX, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT_IDX, 2'b00};

  typedef struct packed {
    logic [7:0] filtered_pixel;
    logic       frame_end;
  } blur_result_t;

  blur_result_t blur_expect[$];

  logic [FW_BITS-1:0] width_reg;
  logic [FH_BITS-1:0] height_reg;
  logic [7:0] pix_ring  [RING_ROWS][LINE_MAX];
  logic [2:0] half_ring [RING_ROWS][LINE_MAX];
  int in_col, in_row;

  function automatic logic [2:0] window_half(input logic [7:0] edist);
    logic [2:0] h;
    if (edist <= 1) h = 3'd0;
    else if (edist <= 3) h = 3'd1;
    else if (edist <= 5) h = 3'd2;
    else if (edist <= 7) h = 3'd3;
    else h = 3'd4;
    if (h > HALF) h = 3'(HALF);
    return h;
  endfunction

  task automatic predict_blur(input logic [7:0] pix, input logic [7:0] edist, input logic pad);
    int w, ht, total, lag, q, p, orow, ocol, h, r0, r1, c0, c1, sum, cnt;
    blur_result_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : int'(width_reg));
    ht = (height_reg == 0) ? 1 : int'(height_reg);
    total = w * ht;
    lag = HALF * w + HALF;
    q = in_row * w + in_col;
    if (in_row < ht && in_col < w) begin
      pix_ring[in_row % RING_ROWS][in_col]  = pad ? 8'd0 : pix;
      half_ring[in_row % RING_ROWS][in_col] = pad ? 3'd0 : window_half(edist);
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (q < lag) return;
    p = q - lag;
    if (p >= total) begin
      in_col = 0;
      in_row = 0;
      return;
    end
    orow = p / w;
    ocol = p % w;
    h = int'(half_ring[orow % RING_ROWS][ocol]);
    if (h == 0) begin
      res.filtered_pixel = pix_ring[orow % RING_ROWS][ocol];
    end else begin
      r0 = (orow >= h) ? orow - h : 0;
      r1 = (orow + h < ht) ? orow + h : ht - 1;
      c0 = (ocol >= h) ? ocol - h : 0;
      c1 = (ocol + h < w) ? ocol + h : w - 1;
      sum = 0;
      for (int r = r0; r <= r1; r++)
        for (int c = c0; c <= c1; c++)
          sum += int'(pix_ring[r % RING_ROWS][c]);
      cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
      res.filtered_pixel = 8'(sum / cnt);
    end
    res.frame_end = (p == total - 1);
    if (res.frame_end) begin
      in_col = 0;
      in_row = 0;
    end
    blur_expect.push_back(res);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    width_reg = FW_RESET;
    height_reg = FH_RESET;
    in_col = 0;
    in_row = 0;
  end

  always @(posedge clk) begin
    blur_result_t want;
    if (!rst_n) begin
      width_reg <= FW_RESET;
      height_reg <= FH_RESET;
      in_col = 0;
      in_row = 0;
      blur_expect.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_WIDTH) begin
          width_reg <= pwdata[FW_BITS-1:0];
          in_col = 0;
          in_row = 0;
        end else if (paddr == ADDR_HEIGHT) begin
          height_reg <= pwdata[FH_BITS-1:0];
          in_col = 0;
          in_row = 0;
        end
      end
      if (in_push && !in_full)
        predict_blur(in_pixel, in_edge_distance, in_is_padding);
      if (out_pop && !out_empty) begin
        if (blur_expect.size() == 0) begin
          $error("unexpected result: filtered_pixel %0d frame_end %0d",
                 out_filtered_pixel, out_frame_end);
          errors++;
        end else begin
          want = blur_expect.pop_front();
          if (out_filtered_pixel !== want.filtered_pixel) begin
            $error("filtered_pixel: expected %0d, got %0d",
                   want.filtered_pixel, out_filtered_pixel);
            errors++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_frame_end);
            errors++;
          end
        end
      end
    end
    pending = blur_expect.size();
  end
endmodule
`default_nettype wire

// ===== tb/sv/edge_adaptive_box_blur_tb.sv =====
// Top of the edge-adaptive box blur testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none
module edge_adaptive_box_blur_tb;
  import eabb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH_IDX, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT_IDX, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_pixel = '0;
  logic [7:0]  in_edge_distance = '0;
  logic        in_is_padding = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_filtered_pixel;
  logic        out_frame_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending;
  int tx_idle_pct = 9;
  int rx_idle_pct = 59;
  int random_items = 0;
  int cycles = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  edge_adaptive_box_blur uut (.*);

  edge_adaptive_box_blur_checker chk (
    .clk, .rst_n, .in_push, .in_full, .in_pixel, .in_edge_distance, .in_is_padding,
    .out_empty, .out_pop, .out_filtered_pixel, .out_frame_end,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random pops, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] pix, input logic [7:0] edist, input logic pad);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_pixel <= pix;
    in_edge_distance <= edist;
    in_is_padding <= pad;
    do @(posedge clk); while (in_full);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // block idle: no result due, and time for any item still inside
  task automatic settle();
    in_push <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    settle();
    cfg_write(ADDR_WIDTH, w);
    cfg_write(ADDR_HEIGHT, h);
  endtask

  // one full frame of random content plus the drain items
  task automatic run_frame(input int w_reg, input int h_reg, input bit pause_mid);
    int w, h, total, n;
    logic [7:0] edist;
    w = (w_reg == 0) ? 1 : ((w_reg > 1024) ? 1024 : w_reg);
    h = (h_reg == 0) ? 1 : h_reg;
    total = w * h;
    n = total + 4 * w + 4;
    for (int q = 0; q < n; q++) begin
      if (pause_mid && q == total / 2) begin
        in_push <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
      edist = ($urandom_range(1)) ? 8'($urandom_range(9)) : 8'($urandom_range(255));
      if (q < total)
        send_item(8'($urandom_range(255)), edist, $urandom_range(9) == 0);
      else
        // after the frame: mostly padding, sometimes a stray pixel
        send_item(8'($urandom_range(255)), edist, $urandom_range(3) != 0);
      random_items++;
    end
  endtask

  initial begin
    logic [7:0] d_dist [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 255, 9, 3};
    logic [7:0] d_pix  [12] = '{0, 255, 255, 0, 128, 255, 1, 254, 255, 0, 77, 255};
    int w, h;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4x3 frame, every window size, extremes, padding inside the frame
    cfg_write(ADDR_WIDTH, 4);
    cfg_write(ADDR_HEIGHT, 3);
    for (int i = 0; i < 12; i++)
      send_item(d_pix[i], d_dist[i], i == 6);
    for (int i = 0; i < 20; i++)
      send_item(8'hff, 8'hff, i != 3);
    // zero sizes count as 1
    set_frame(0, 0);
    for (int i = 0; i < 9; i++)
      send_item(8'd200, 8'd255, i != 0);
    random_items = 0;

    while (random_items < 1000) begin
      if (random_items < 330) begin
        tx_idle_pct = 9;
        rx_idle_pct = 59;
      end else if (random_items < 660) begin
        tx_idle_pct = 59;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      w = ($urandom_range(4) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
      h = $urandom_range(10, 1);
      set_frame(w, h);
      if (tx_idle_pct == 0 && !hold_req)
        hold_req <= 1'b1;
      run_frame(w, h, $urandom_range(5) == 0);
      if ($urandom_range(2) == 0)
        run_frame(w, h, 1'b0);
    end

    // size extremes: height register at its top, left unfinished, then a small frame
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_frame(1, 8191);
    run_frame(1, 1, 1'b0);
    set_frame(3, 5);
    run_frame(3, 5, 1'b0);

    settle();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
